// File: src/apsp_pkg.sv
// shared types and constants of the all-pairs shortest path unit
// no dependencies; imported by the top level and apsp_relax
package apsp_pkg;

    localparam int DEF_MAX_VERTICES = 8;
    localparam int DEF_WEIGHT_BITS  = 16;

    // fixed field widths of the stream and configuration ports
    localparam int WEIGHT_FIELD_BITS = 16;
    localparam int DIST_FIELD_BITS   = 16;
    localparam int VC_BITS           = 4;
    localparam logic [VC_BITS-1:0] VC_RESET = 4'd8;

    // relaxation sequencer status toward the top level
    typedef struct packed {
        logic running;   // reads still being issued
        logic draining;  // compare and write-back pending
    } t_relax_stat;

endpackage

// File: src/all_pairs_shortest_path_unit.sv
// all-pairs shortest path unit (floyd-warshall) top level
// depends on apsp_pkg, apsp_mem and apsp_relax
//
//  channel   | dir | handshake                | payload
//  ----------+-----+--------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid/tready     | tdata[15:0] weight
//  m_axis    | out | m_axis_tvalid/tready     | tdata[15:0] distance, tlast last
//  cfg       | in  | i_cfg_we (no wait)       | i_cfg_wdata[3:0] vertex_count
//
// loading takes n*n words. the word that completes the matrix starts the relax
// phase, which walks each row as one row-start fetch of d[i][k] on read port b
// of the distance memory and then its columns, drains the last
// write-back and hands over to read-out. the first distance passes the port a
// register and the output register, then one word per cycle while m_axis_tready
// holds.
// reset clears control only, the distance memory needs no clearing pass.
// s_axis_tready is low from the completing word until the last distance leaves.
module all_pairs_shortest_path_unit #(
    parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = apsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [apsp_pkg::VC_BITS-1:0]  i_cfg_wdata,     // vertex_count
    // weight stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [apsp_pkg::WEIGHT_FIELD_BITS-1:0] s_axis_tdata, // [15:0] weight
    // distance stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [apsp_pkg::DIST_FIELD_BITS-1:0] m_axis_tdata,   // [15:0] distance
    output logic                          m_axis_tlast
);

    import apsp_pkg::*;

    localparam int IB = $clog2(MAX_VERTICES);   // row or column index bits
    localparam int AW = 2 * IB;                 // memory address {row, col}
    localparam int W  = WEIGHT_BITS;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RELAX = 3'b010,
        ST_OUT   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [VC_BITS-1:0] r_vc;
    logic [VC_BITS-1:0] side;
    logic [VC_BITS-1:0] side_m1_full;
    logic [IB-1:0]      side_m1;

    // load position
    logic [IB-1:0] r_row;
    logic [IB-1:0] r_col;
    // output read position
    logic [IB-1:0] r_orow;
    logic [IB-1:0] r_ocol;
    logic          r_iss_more;   // reads left to issue
    logic          r_rd_pend;    // read data waiting on port a
    logic          r_pend_last;
    logic          r_out_valid;
    logic          r_out_last;
    logic [DIST_FIELD_BITS-1:0] r_out_data;

    logic in_acc;
    logic load_last;
    logic out_take;
    logic out_load;
    logic out_issue;
    logic iss_last;

    logic [W+WEIGHT_FIELD_BITS-1:0] w_ext;
    logic [W+DIST_FIELD_BITS-1:0]   q_ext;

    // memory port wiring
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic          mem_re_a;
    logic [AW-1:0] mem_raddr_a;
    logic          mem_re_b;
    logic [AW-1:0] mem_raddr_b;
    logic [W-1:0]  q_a;
    logic [W-1:0]  q_b;

    logic          rx_re_a;
    logic [AW-1:0] rx_raddr_a;
    logic          rx_re_b;
    logic [AW-1:0] rx_raddr_b;
    logic          rx_we;
    logic [AW-1:0] rx_waddr;
    logic [W-1:0]  rx_wdata;
    t_relax_stat   rx_stat;
    logic          rx_start;

    // side length clamped to 1 .. MAX_VERTICES
    always_comb begin
        side = r_vc;
        if (r_vc == '0) begin
            side = VC_BITS'(1);
        end else if (r_vc > VC_BITS'(MAX_VERTICES)) begin
            side = VC_BITS'(MAX_VERTICES);
        end
    end
    assign side_m1_full = side - 1'b1;
    assign side_m1      = side_m1_full[IB-1:0];

    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_last     = (r_row == side_m1) && (r_col == side_m1);
    assign rx_start      = in_acc && load_last;

    // weight masked to the stored width
    assign w_ext = {{W{1'b0}}, s_axis_tdata};

    // output side: port a data waits in its register until the out stage frees
    assign out_take  = r_out_valid && m_axis_tready;
    assign out_load  = r_rd_pend && (!r_out_valid || m_axis_tready);
    assign out_issue = (r_state == ST_OUT) && r_iss_more && (!r_rd_pend || out_load);
    assign iss_last  = (r_orow == side_m1) && (r_ocol == side_m1);
    assign q_ext     = {{DIST_FIELD_BITS{1'b0}}, q_a};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (rx_start) begin
                    n_state = ST_RELAX;
                end
            end
            ST_RELAX: begin
                if (!(rx_stat.running || rx_stat.draining)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_take && r_out_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_vc        <= VC_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_iss_more  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state <= n_state;

            // load position; a register write restarts the matrix
            if (i_cfg_we) begin
                r_vc  <= i_cfg_wdata;
                r_row <= '0;
                r_col <= '0;
            end else if (in_acc) begin
                if (r_col == side_m1) begin
                    r_col <= '0;
                    r_row <= (r_row == side_m1) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            // read-out sequencing
            if (r_state == ST_RELAX && n_state == ST_OUT) begin
                r_iss_more <= 1'b1;
                r_orow     <= '0;
                r_ocol     <= '0;
            end else if (out_issue) begin
                if (iss_last) begin
                    r_iss_more <= 1'b0;
                end
                if (r_ocol == side_m1) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end

            if (out_issue) begin
                r_rd_pend   <= 1'b1;
                r_pend_last <= iss_last;
            end else if (out_load) begin
                r_rd_pend <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_last  <= r_pend_last;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
                r_out_last  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= q_ext[DIST_FIELD_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // memory port arbitration by phase
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = {r_row, r_col};
        mem_wdata   = w_ext[W-1:0];
        mem_re_a    = 1'b0;
        mem_raddr_a = {r_orow, r_ocol};
        mem_re_b    = 1'b0;
        mem_raddr_b = rx_raddr_b;
        case (r_state)
            ST_LOAD: begin
                mem_we = in_acc;
            end
            ST_RELAX: begin
                mem_we      = rx_we;
                mem_waddr   = rx_waddr;
                mem_wdata   = rx_wdata;
                mem_re_a    = rx_re_a;
                mem_raddr_a = rx_raddr_a;
                mem_re_b    = rx_re_b;
            end
            ST_OUT: begin
                mem_re_a = out_issue;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    apsp_mem #(
        .AW (AW),
        .W  (W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re_a    (mem_re_a),
        .i_raddr_a (mem_raddr_a),
        .i_re_b    (mem_re_b),
        .i_raddr_b (mem_raddr_b),
        .o_q_a     (q_a),
        .o_q_b     (q_b)
    );

    apsp_relax #(
        .IB (IB),
        .W  (W)
    ) u_relax (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rx_start),
        .i_side_m1 (side_m1),
        .i_q_a     (q_a),
        .i_q_b     (q_b),
        .o_re_a    (rx_re_a),
        .o_raddr_a (rx_raddr_a),
        .o_re_b    (rx_re_b),
        .o_raddr_b (rx_raddr_b),
        .o_we      (rx_we),
        .o_waddr   (rx_waddr),
        .o_wdata   (rx_wdata),
        .o_stat    (rx_stat)
    );

    // input and output phases never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while distances are still leaving");

    // the relaxation never runs outside its phase
    a_relax_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_stat.running || rx_stat.draining) |-> (r_state == ST_RELAX))
        else $error("relaxation active outside its phase");

    // no read left behind once the final distance is presented
    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (!r_iss_more && !r_rd_pend))
        else $error("final distance presented with reads outstanding");

    // the completing word starts the relaxation on the next cycle
    a_relax_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_start |=> rx_stat.running)
        else $error("relaxation did not start after the last weight");

endmodule

// File: src/apsp_mem.sv
// distance matrix storage: two mirrored synchronous memories, one write port,
// one registered read port each; depends on nothing
module apsp_mem #(
    parameter int AW = 6,
    parameter int W  = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re_a,
    input  logic [AW-1:0] i_raddr_a,
    input  logic          i_re_b,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_q_a,
    output logic [W-1:0]  o_q_b
);

    localparam int DEPTH = 1 << AW;

    logic [W-1:0] r_mem_a [DEPTH];
    logic [W-1:0] r_mem_b [DEPTH];
    logic [W-1:0] r_q_a;
    logic [W-1:0] r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_q_a <= r_mem_a[i_raddr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_re_b) begin
            r_q_b <= r_mem_b[i_raddr_b];
        end
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule

// File: src/apsp_relax.sv
// floyd-warshall sequencer: walks pivot k, row i, column j over the memories,
// compares and writes back; depends on apsp_pkg
module apsp_relax #(
    parameter int IB = 3,
    parameter int W  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [IB-1:0]        i_side_m1,
    input  logic [W-1:0]         i_q_a,
    input  logic [W-1:0]         i_q_b,
    output logic                 o_re_a,
    output logic [2*IB-1:0]      o_raddr_a,
    output logic                 o_re_b,
    output logic [2*IB-1:0]      o_raddr_b,
    output logic                 o_we,
    output logic [2*IB-1:0]      o_waddr,
    output logic [W-1:0]         o_wdata,
    output apsp_pkg::t_relax_stat o_stat
);

    import apsp_pkg::*;

    logic            r_active;
    logic            r_hdr;      // row start: fetch d[i][k]
    logic            r_cap;      // d[i][k] sits on port b
    logic            r_cmp_valid;
    logic [IB-1:0]   r_k;
    logic [IB-1:0]   r_i;
    logic [IB-1:0]   r_j;
    logic [W-1:0]    r_dik;
    logic [2*IB-1:0] r_cmp_addr;
    logic [W:0]      via;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_hdr       <= 1'b0;
            r_cap       <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_cap       <= r_active && r_hdr;
            r_cmp_valid <= r_active && !r_hdr;
            if (i_start) begin
                r_active <= 1'b1;
                r_hdr    <= 1'b1;
                r_k      <= '0;
                r_i      <= '0;
                r_j      <= '0;
            end else if (r_active) begin
                if (r_hdr) begin
                    r_hdr <= 1'b0;
                    r_j   <= '0;
                end else if (r_j == i_side_m1) begin
                    r_hdr <= 1'b1;
                    r_j   <= '0;
                    if (r_i == i_side_m1) begin
                        r_i <= '0;
                        if (r_k == i_side_m1) begin
                            r_active <= 1'b0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= {r_i, r_j};
        if (r_cap) begin
            r_dik <= i_q_b;
        end
    end

    // row k and column k do not change under pivot k, so no hazard on reads
    assign o_re_a    = r_active && !r_hdr;
    assign o_raddr_a = {r_i, r_j};
    assign o_re_b    = r_active;
    assign o_raddr_b = r_hdr ? {r_i, r_k} : {r_k, r_j};

    assign via     = {1'b0, r_dik} + {1'b0, i_q_b};
    assign o_we    = r_cmp_valid && (via < {1'b0, i_q_a});
    assign o_waddr = r_cmp_addr;
    assign o_wdata = via[W-1:0];

    assign o_stat.running  = r_active;
    assign o_stat.draining = r_cmp_valid;

endmodule
